[src/slrg_pkg.sv]
// Package for the linear-ramp stepper profile generator.
// Holds the word structs, mode and sequencer enums and fixed constants.
// No dependencies; every module of the block imports it.
package slrg_pkg;

	localparam int DELAY_BITS    = 16;
	localparam int TIMER_BITS    = 16;
	localparam int FIXED_BITS    = 31;
	localparam int FRAC_BITS     = 8;
	localparam int ROUND_HALF    = 128;
	localparam int DIV_BITS      = FIXED_BITS + 2;
	localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
	localparam int DEN_STEP      = 4;
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic [DELAY_BITS-1:0] START_DELAY_RST = 16'd50000;
	localparam logic [DELAY_BITS-1:0] MIN_DELAY_RST   = 16'd2500;
	localparam logic [DELAY_BITS-1:0] FIRST_LEAD_RST  = 16'd1000;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	typedef enum logic [1:0] {
		REG_START_DELAY = 2'd0,
		REG_MIN_DELAY   = 2'd1,
		REG_FIRST_LEAD  = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'd0,
		MODE_ACCEL = 3'd1,
		MODE_CONST = 3'd2,
		MODE_DECEL = 3'd3,
		MODE_LAST  = 3'd4
	} ramp_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_FIX,
		ST_ROUND,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic                   command;
		logic signed [15:0]     target_position;
		logic [TIMER_BITS-1:0]  timer_now;
	} cmd_word_t;

	typedef struct packed {
		logic                   stepped;
		logic [1:0]             phase_code;
		logic signed [15:0]     position;
		logic [TIMER_BITS-1:0]  compare_value;
		logic [DELAY_BITS-1:0]  step_delay;
		logic [2:0]             ramp_phase;
		logic                   running;
	} res_word_t;

endpackage

[src/stepper_linear_ramp_generator.sv]
// Top level of the linear-ramp stepper profile generator.
// Depends on slrg_pkg for word structs, enums and constants.
//
//  channel | direction | handshake              | word
//  --------+-----------+------------------------+-----------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | cmd_word (start or tick)
//  res     | out       | res_valid / res_stall  | res_word (one per cmd word)
//  apb     | in/out    | psel, penable, pready  | 16-bit registers at 0, 4, 8
//
// A start command or a tick that needs no new delay goes through EXEC and EMIT
// into the result register. A tick in accel or decel that computes a new delay
// goes through EXEC, DIV, FIX, ROUND and EMIT, with the bit-serial divider in
// DIV (33 iterations). Reset clears the ramp state to idle at position zero
// and loads the register defaults. The block takes one word at a time;
// cmd_stall is high from acceptance until the result has moved into the
// output register, and a stalled result register holds the finished word
// while the block is idle.
module stepper_linear_ramp_generator #(
	parameter int POS_WIDTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [slrg_pkg::APB_ADDR_BITS-1:0]  paddr,
	input  logic [slrg_pkg::APB_DATA_BITS-1:0]  pwdata,
	output logic [slrg_pkg::APB_DATA_BITS-1:0]  prdata,
	output logic                                pready,
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  slrg_pkg::cmd_word_t                 cmd_word,
	output logic                                res_valid,
	input  logic                                res_stall,
	output slrg_pkg::res_word_t                 res_word
);
	import slrg_pkg::*;

	// Step counters carry one bit more than the position; the 4n+1
	// denominator carries three more than the counters.
	localparam int CW = POS_WIDTH + 1;
	localparam int DW = POS_WIDTH + 4;

	function automatic logic [1:0] next_phase(input logic [1:0] ph, input logic down);
		next_phase = down ? ph - 2'd1 : ph + 2'd1;
	endfunction

	// Configuration registers.
	logic [DELAY_BITS-1:0] start_delay_q, min_delay_q, first_lead_q;

	// Architectural ramp state.
	seq_state_t              state_q, state_d;
	ramp_mode_t              mode_q, mode_d;
	logic signed [POS_WIDTH-1:0] pos_q, pos_d;
	logic                    dir_q, dir_d;
	logic [1:0]              phase_q, phase_d;
	logic [CW-1:0]           steps_q, steps_d;
	logic [CW-1:0]           len_q, len_d;
	logic [CW-1:0]           mid_q, mid_d;
	logic [CW-1:0]           decel_q, decel_d;
	logic [DELAY_BITS-1:0]   dint_q, dint_d;
	logic [FIXED_BITS-1:0]   fixed_q, fixed_d;
	logic signed [DW-1:0]    den_q, den_d;
	logic [TIMER_BITS-1:0]   cmp_q, cmp_d;
	logic                    busy_q, busy_d;
	logic                    stepped_q, stepped_d;

	// Captured command word and result register.
	cmd_word_t               cmd_q;
	res_word_t               res_q;
	logic                    res_valid_q;

	// Divider state.
	logic [DW-1:0]           rem_q;
	logic [DIV_BITS-1:0]     quo_q;
	logic [DW-1:0]           dmag_q;
	logic                    den_neg_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DW:0]             div_trial;
	logic [DW-1:0]           den_mag;

	// Sequencer controls.
	logic                    cmd_take;
	logic                    out_load;
	logic                    div_load;
	logic                    tail_en;
	logic                    need_update;
	logic signed [DW-1:0]    den_base;

	// Helper values for the start command and mode changes.
	logic signed [31:0]          tgt_ext;
	logic signed [POS_WIDTH-1:0] tgt;
	logic signed [POS_WIDTH:0]   move_diff;
	logic [CW-1:0]               move_mag;
	logic                        is_last;
	logic [DW-1:0]               span;
	logic [DW-1:0]               den_mid1;
	logic [DW-1:0]               den_mid5;
	logic [DIV_BITS+1:0]         fix_sum;
	logic [FIXED_BITS:0]         rnd_sum;
	logic [FIXED_BITS-FRAC_BITS:0] rnd_int;
	logic [DELAY_BITS-1:0]       rnd_delay;
	logic signed [31:0]          pos_ext;

	// ------------------------------------------------------------------
	// Configuration port. Writes land on the access phase; reads are
	// combinational and unmapped addresses read as zero.
	// ------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_delay_q <= START_DELAY_RST;
			min_delay_q   <= MIN_DELAY_RST;
			first_lead_q  <= FIRST_LEAD_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_START_DELAY: start_delay_q <= pwdata[DELAY_BITS-1:0];
				REG_MIN_DELAY:   min_delay_q   <= pwdata[DELAY_BITS-1:0];
				REG_FIRST_LEAD:  first_lead_q  <= pwdata[DELAY_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_START_DELAY: prdata = APB_DATA_BITS'(start_delay_q);
			REG_MIN_DELAY:   prdata = APB_DATA_BITS'(min_delay_q);
			REG_FIRST_LEAD:  prdata = APB_DATA_BITS'(first_lead_q);
			default:         prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Datapath helpers.
	// ------------------------------------------------------------------
	// The 16-bit target is wrapped or sign-extended to the position width.
	assign tgt_ext   = 32'(cmd_q.target_position);
	assign tgt       = tgt_ext[POS_WIDTH-1:0];
	assign move_diff = (POS_WIDTH+1)'(tgt) - (POS_WIDTH+1)'(pos_q);
	assign move_mag  = move_diff[POS_WIDTH] ? unsigned'(-move_diff) : unsigned'(move_diff);

	// The move is on its final step when the counter is one short of the length.
	assign is_last = (steps_q == len_q - CW'(1));

	// Denominator for entering decel: 4*(steps - length) plus one or five,
	// wrapped to the denominator width.
	assign span     = DW'(steps_q) - DW'(len_q);
	assign den_mid1 = {span[DW-3:0], 2'b00} + DW'(1);
	assign den_mid5 = {span[DW-3:0], 2'b00} + DW'(DEN_STEP + 1);

	// Magnitude of the new denominator as it goes into the divider.
	assign den_mag = den_d[DW-1] ? unsigned'(-den_d) : unsigned'(den_d);

	// One restoring-division step: shift in the next dividend bit and try
	// subtracting the divisor magnitude.
	assign div_trial = {rem_q, quo_q[DIV_BITS-1]} - {1'b0, dmag_q};

	// D' = D - q with q the truncated quotient. A negative denominator flips
	// the sign of q, so the magnitude is added instead. Clamp to 0..2^31-1.
	assign fix_sum = den_neg_q ? (DIV_BITS+2)'(fixed_q) + (DIV_BITS+2)'(quo_q)
	                           : (DIV_BITS+2)'(fixed_q) - (DIV_BITS+2)'(quo_q);

	// Round the 23.8 delay to ticks and saturate at the 16-bit maximum.
	assign rnd_sum   = (FIXED_BITS+1)'(fixed_q) + (FIXED_BITS+1)'(ROUND_HALF);
	assign rnd_int   = rnd_sum[FIXED_BITS:FRAC_BITS];
	assign rnd_delay = (rnd_int > (FIXED_BITS-FRAC_BITS+1)'({DELAY_BITS{1'b1}}))
	                   ? {DELAY_BITS{1'b1}} : rnd_int[DELAY_BITS-1:0];

	// ------------------------------------------------------------------
	// Sequencer: state register.
	// ------------------------------------------------------------------
	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			mode_q    <= MODE_IDLE;
			pos_q     <= '0;
			dir_q     <= 1'b0;
			phase_q   <= '0;
			steps_q   <= '0;
			len_q     <= '0;
			mid_q     <= '0;
			decel_q   <= '0;
			dint_q    <= '0;
			fixed_q   <= '0;
			den_q     <= '0;
			cmp_q     <= '0;
			busy_q    <= 1'b0;
			stepped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			mode_q    <= mode_d;
			pos_q     <= pos_d;
			dir_q     <= dir_d;
			phase_q   <= phase_d;
			steps_q   <= steps_d;
			len_q     <= len_d;
			mid_q     <= mid_d;
			decel_q   <= decel_d;
			dint_q    <= dint_d;
			fixed_q   <= fixed_d;
			den_q     <= den_d;
			cmp_q     <= cmp_d;
			busy_q    <= busy_d;
			stepped_q <= stepped_d;
		end
	end

	// ------------------------------------------------------------------
	// Sequencer: next state and ramp update.
	// EXEC handles the start command and every tick that needs no division.
	// A tick that recomputes the delay goes EXEC, DIV, FIX, ROUND. The step
	// itself (position, counter, phase) is applied once the final mode for
	// the tick is known, in EXEC or in ROUND.
	// ------------------------------------------------------------------
	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		pos_d       = pos_q;
		dir_d       = dir_q;
		phase_d     = phase_q;
		steps_d     = steps_q;
		len_d       = len_q;
		mid_d       = mid_q;
		decel_d     = decel_q;
		dint_d      = dint_q;
		fixed_d     = fixed_q;
		den_d       = den_q;
		cmp_d       = cmp_q;
		busy_d      = busy_q;
		stepped_d   = stepped_q;
		div_load    = 1'b0;
		tail_en     = 1'b0;
		need_update = 1'b0;
		den_base    = den_q;
		out_load    = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					state_d = ST_EXEC;
				end
			end

			ST_EXEC: begin
				state_d   = ST_EMIT;
				stepped_d = 1'b0;
				if (cmd_q.command == CMD_START) begin
					// A start to the present position leaves the ramp state as it is and only clears the step flag.
					if (move_diff != '0) begin
						dir_d     = move_diff[POS_WIDTH];
						len_d     = move_mag;
						mid_d     = (move_mag - CW'(1)) >> 1;
						dint_d    = start_delay_q;
						fixed_d   = {{(FIXED_BITS-DELAY_BITS-FRAC_BITS){1'b0}},
						             start_delay_q, {FRAC_BITS{1'b0}}};
						steps_d   = '0;
						den_d     = DW'(1);
						mode_d    = MODE_ACCEL;
						busy_d    = 1'b1;
						cmp_d     = cmd_q.timer_now + first_lead_q;
						phase_d   = next_phase(phase_q, move_diff[POS_WIDTH]);
						stepped_d = 1'b1;
					end
				end else if (mode_q != MODE_IDLE) begin
					cmp_d   = cmp_q + dint_q;
					tail_en = 1'b1;
					case (mode_q)
						MODE_ACCEL: begin
							if (steps_q == mid_q) begin
								// Midpoint reached before top speed: mirror into decel.
								mode_d = MODE_DECEL;
								if (!len_q[0]) begin
									den_d = den_mid1 + DW'(DEN_STEP);
								end else begin
									need_update = 1'b1;
									den_base    = den_mid1;
								end
							end else begin
								need_update = 1'b1;
							end
						end
						MODE_DECEL: begin
							need_update = 1'b1;
						end
						MODE_CONST: begin
							if (steps_q == decel_q) begin
								mode_d = MODE_DECEL;
								den_d  = den_mid5;
							end
						end
						default: begin
							// Last tick: back to idle without a step.
							mode_d = MODE_IDLE;
							busy_d = 1'b0;
						end
					endcase
					if (need_update) begin
						if (is_last) begin
							mode_d = MODE_LAST;
						end else begin
							den_d    = den_base + DW'(DEN_STEP);
							div_load = 1'b1;
							tail_en  = 1'b0;
							state_d  = ST_DIV;
						end
					end
				end
			end

			ST_DIV: begin
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					state_d = ST_FIX;
				end
			end

			ST_FIX: begin
				if (fix_sum[DIV_BITS+1]) begin
					fixed_d = '0;
				end else if (|fix_sum[DIV_BITS:FIXED_BITS]) begin
					fixed_d = {FIXED_BITS{1'b1}};
				end else begin
					fixed_d = fix_sum[FIXED_BITS-1:0];
				end
				state_d = ST_ROUND;
			end

			ST_ROUND: begin
				if (rnd_delay <= min_delay_q) begin
					// Top speed reached: hold it and note where decel begins.
					mode_d  = MODE_CONST;
					decel_d = len_q - steps_q;
					dint_d  = min_delay_q;
				end else begin
					dint_d = rnd_delay;
				end
				tail_en = 1'b1;
				state_d = ST_EMIT;
			end

			ST_EMIT: begin
				if (!res_valid_q || !res_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// The step that every tick of a running move makes, but for the closing tick.
		if (tail_en && mode_d != MODE_IDLE) begin
			pos_d   = dir_q ? pos_q - POS_WIDTH'(1) : pos_q + POS_WIDTH'(1);
			steps_d = steps_q + CW'(1);
			if (mode_d != MODE_LAST) begin
				phase_d   = next_phase(phase_q, dir_q);
				stepped_d = 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Bit-serial divider: 2*D over |den|, one quotient bit per cycle.
	// The dividend sits in the quotient register and shifts out at the top
	// while quotient bits shift in at the bottom.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_load) begin
			cnt_q <= DIV_CNT_BITS'(DIV_BITS);
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q - DIV_CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (div_load) begin
			rem_q     <= '0;
			quo_q     <= DIV_BITS'({fixed_q, 1'b0});
			dmag_q    <= den_mag;
			den_neg_q <= den_d[DW-1];
		end else if (state_q == ST_DIV) begin
			if (!div_trial[DW]) begin
				rem_q <= div_trial[DW-1:0];
			end else begin
				rem_q <= {rem_q[DW-2:0], quo_q[DIV_BITS-1]};
			end
			quo_q <= {quo_q[DIV_BITS-2:0], ~div_trial[DW]};
		end
	end

	// ------------------------------------------------------------------
	// Command capture and result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd_word;
		end
	end

	assign pos_ext = 32'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q.stepped       <= stepped_q;
			res_q.phase_code    <= phase_q ^ {1'b0, phase_q[1]};
			res_q.position      <= pos_ext[15:0];
			res_q.compare_value <= cmp_q;
			res_q.step_delay    <= dint_q;
			res_q.ramp_phase    <= mode_q;
			res_q.running       <= busy_q;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for stepper_linear_ramp_generator.
// Depends on slrg_pkg and the block's RTL; it needs no other file.
module tb;

	import slrg_pkg::*;

	// Clock, reset and the three ports of the block.
	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_BITS-1:0] paddr;
	logic [APB_DATA_BITS-1:0] pwdata;
	logic [APB_DATA_BITS-1:0] prdata;
	logic pready;
	logic cmd_valid;
	logic cmd_stall;
	cmd_word_t cmd_word;
	logic res_valid;
	logic res_stall;
	res_word_t res_word;

	stepper_linear_ramp_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_word  (cmd_word),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

	// 100 MHz clock.
	always #5 clk = ~clk;

	// Idle rates, in percent, of the command sender and the result receiver.
	int send_pct = 0;
	int stall_pct = 0;

	int errors = 0;
	int work_items = 0;
	int words_seen = 0;

	// Result words that the profile model says are still on their way, oldest first.
	res_word_t ramp_results_due[$];

	// Our copy of the three registers, kept in step with every APB write.
	logic [15:0] cfg_start_delay = START_DELAY_RST;
	logic [15:0] cfg_min_delay   = MIN_DELAY_RST;
	logic [15:0] cfg_lead        = FIRST_LEAD_RST;

	// Profile model state. The delay is held in 23.8 fixed point and the ramp
	// denominator is a 20-bit signed counter that wraps.
	ramp_mode_t  prof_mode  = MODE_IDLE;
	logic [15:0] prof_pos   = '0;
	logic        prof_down  = 1'b0;
	logic [1:0]  prof_phase = '0;
	logic [16:0] prof_steps = '0;
	logic [16:0] prof_len   = '0;
	logic [16:0] prof_mid   = '0;
	logic [16:0] prof_decel_at = '0;
	logic [15:0] prof_delay = '0;
	longint      prof_fixed = 0;
	longint      prof_den   = 0;
	logic [15:0] prof_cmp   = '0;
	logic        prof_busy  = 1'b0;

	// One row of the directed table. Rows with a typed-in result are checked
	// against that value; the others fall back to the profile model.
	typedef struct {
		logic        command;
		logic [15:0] target;
		logic [15:0] timer;
		bit          typed;
		res_word_t   want;
	} plan_row_t;

	plan_row_t plan[$];

	// One line per mismatch, and every one is counted.
	task automatic flag(input string msg);
		errors++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	function automatic longint wrap_den20(input longint v);
		logic signed [19:0] b;
		b = v[19:0];
		return b;
	endfunction

	function automatic void step_phase();
		if (prof_down)
			prof_phase = prof_phase - 2'd1;
		else
			prof_phase = prof_phase + 2'd1;
	endfunction

	// Moves the ramp on by one step of the linear recurrence. The final step of
	// the move ends in the last mode instead. If the rounded delay has come down
	// to the top-speed limit, the ramp switches to constant speed and notes how
	// many steps remain, which is where the decel has to start.
	function automatic void next_delay();
		longint r;
		if (prof_steps == prof_len - 17'd1) begin
			prof_mode = MODE_LAST;
		end else begin
			prof_den = wrap_den20(prof_den + DEN_STEP);
			prof_fixed = prof_fixed - (prof_fixed * 2) / prof_den;
			if (prof_fixed < 0)
				prof_fixed = 0;
			if (prof_fixed > 64'sd2147483647)
				prof_fixed = 64'sd2147483647;
			r = (prof_fixed + ROUND_HALF) / 256;
			if (r > 65535)
				r = 65535;
			prof_delay = r[15:0];
			if (prof_delay <= cfg_min_delay) begin
				prof_mode = MODE_CONST;
				prof_decel_at = prof_len - prof_steps;
				prof_delay = cfg_min_delay;
			end
		end
	endfunction

	// Works out the result word for one accepted command word and updates the
	// model state the way the block is meant to.
	function automatic res_word_t profile_step(input cmd_word_t w);
		res_word_t r;
		logic signed [15:0] tgt;
		logic signed [15:0] here;
		longint span_len;
		logic moved;
		moved = 1'b0;
		if (w.command == CMD_START) begin
			tgt = w.target_position;
			here = prof_pos;
			// A start towards the present position is a no-op, even mid-move.
			if (tgt != here) begin
				span_len = (tgt < here) ? longint'(here) - longint'(tgt)
					: longint'(tgt) - longint'(here);
				prof_down = (tgt < here);
				prof_len = span_len[16:0];
				prof_mid = 17'((span_len - 1) >>> 1);
				prof_delay = cfg_start_delay;
				prof_fixed = longint'(cfg_start_delay) << FRAC_BITS;
				prof_steps = '0;
				prof_den = 1;
				prof_mode = MODE_ACCEL;
				prof_busy = 1'b1;
				prof_cmp = w.timer_now + cfg_lead;
				step_phase();
				moved = 1'b1;
			end
		end else if (prof_mode != MODE_IDLE) begin
			// Ticks while idle are ignored altogether.
			prof_cmp = prof_cmp + prof_delay;
			case (prof_mode)
				MODE_ACCEL: begin
					if (prof_steps == prof_mid) begin
						// Halfway without reaching top speed: mirror the accel.
						prof_mode = MODE_DECEL;
						prof_den = wrap_den20((longint'(prof_steps) - longint'(prof_len))
							* 4 + 1);
						if (!prof_len[0])
							prof_den = wrap_den20(prof_den + DEN_STEP);
						else
							next_delay();
					end else begin
						next_delay();
					end
				end
				MODE_DECEL: next_delay();
				MODE_CONST: begin
					if (prof_steps == prof_decel_at) begin
						prof_mode = MODE_DECEL;
						prof_den = wrap_den20((longint'(prof_steps) - longint'(prof_len))
							* 4 + 5);
					end
				end
				default: begin
					// The tick after the last step only closes the move.
					prof_mode = MODE_IDLE;
					prof_busy = 1'b0;
				end
			endcase
			if (prof_mode != MODE_IDLE) begin
				prof_pos = prof_down ? prof_pos - 16'd1 : prof_pos + 16'd1;
				prof_steps = prof_steps + 17'd1;
				// The last step moves the position but not the coils.
				if (prof_mode != MODE_LAST) begin
					step_phase();
					moved = 1'b1;
				end
			end
		end
		r.stepped = moved;
		r.phase_code = {prof_phase[1], prof_phase[1] ^ prof_phase[0]};
		r.position = prof_pos;
		r.compare_value = prof_cmp;
		r.step_delay = prof_delay;
		r.ramp_phase = prof_mode;
		r.running = prof_busy;
		return r;
	endfunction

	function automatic res_word_t fixed_result(input logic st, input logic [1:0] pc,
		input logic [15:0] pos, input logic [15:0] cmp, input logic [15:0] dly,
		input ramp_mode_t md, input logic run);
		res_word_t r;
		r.stepped = st;
		r.phase_code = pc;
		r.position = pos;
		r.compare_value = cmp;
		r.step_delay = dly;
		r.ramp_phase = md;
		r.running = run;
		return r;
	endfunction

	function automatic void plan_add(input logic cmd, input logic [15:0] tgt,
		input logic [15:0] tm, input bit typed = 1'b0, input res_word_t want = '0);
		plan_row_t row;
		row.command = cmd;
		row.target = tgt;
		row.timer = tm;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endfunction

	// Offers one command word, after a random gap, and holds it until the block
	// takes it. The expectation is queued at the edge of acceptance, so the
	// model always sees words in the order the block does. Starts and ends at a
	// falling edge, with valid left high so back-to-back words need no toggle.
	task automatic send_word(input cmd_word_t w, input bit typed, input res_word_t want);
		res_word_t pred;
		bit counts;
		while ($urandom_range(99) < send_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= w;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// Ticks while idle and starts to the present position do no work.
		counts = (w.command == CMD_START) ? (w.target_position != prof_pos)
			: (prof_mode != MODE_IDLE);
		if (counts)
			work_items++;
		pred = profile_step(w);
		ramp_results_due.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	// Random timer value, and for ticks a random (ignored) target too.
	task automatic issue(input logic cmd, input logic [15:0] tgt);
		cmd_word_t w;
		w.command = cmd;
		w.target_position = tgt;
		w.timer_now = 16'($urandom);
		send_word(w, 1'b0, '0);
	endtask

	// Stops sending and waits for every outstanding result word.
	task automatic drain();
		cmd_valid <= 1'b0;
		do
			@(negedge clk);
		while (ramp_results_due.size() != 0);
	endtask

	// Writes one register, then reads it back, each access with a setup and an
	// access phase; the bus is left idle at the end.
	task automatic cfg_write(input cfg_reg_t which, input logic [15:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= {16'h0000, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (which)
			REG_START_DELAY: cfg_start_delay = value;
			REG_MIN_DELAY:   cfg_min_delay = value;
			default:         cfg_lead = value;
		endcase
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[15:0] !== value)
			flag($sformatf("register %s read back %h, wrote %h", which.name(),
				prdata[15:0], value));
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	// The receiver stalls at random; the rate changes from phase to phase.
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// Every result word taken from the block is checked against the oldest
	// expectation, one field at a time.
	res_word_t due;

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			words_seen++;
			if (ramp_results_due.size() == 0) begin
				flag($sformatf("result word %0d arrived with nothing expected", words_seen));
			end else begin
				due = ramp_results_due.pop_front();
				if (res_word.stepped !== due.stepped)
					flag($sformatf("word %0d stepped %b, want %b", words_seen,
						res_word.stepped, due.stepped));
				if (res_word.phase_code !== due.phase_code)
					flag($sformatf("word %0d phase_code %b, want %b", words_seen,
						res_word.phase_code, due.phase_code));
				if (res_word.position !== due.position)
					flag($sformatf("word %0d position %0d, want %0d", words_seen,
						res_word.position, due.position));
				if (res_word.compare_value !== due.compare_value)
					flag($sformatf("word %0d compare_value %0d, want %0d", words_seen,
						res_word.compare_value, due.compare_value));
				if (res_word.step_delay !== due.step_delay)
					flag($sformatf("word %0d step_delay %0d, want %0d", words_seen,
						res_word.step_delay, due.step_delay));
				if (res_word.ramp_phase !== due.ramp_phase)
					flag($sformatf("word %0d ramp_phase %0d, want %0d", words_seen,
						res_word.ramp_phase, due.ramp_phase));
				if (res_word.running !== due.running)
					flag($sformatf("word %0d running %b, want %b", words_seen,
						res_word.running, due.running));
			end
		end
	end

	// Watchdog: a run that has not finished in time ends with an error.
	initial begin
		#3_000_000;
		$display("[stepper_linear_ramp_generator] ERROR");
		$finish;
	end

	initial begin : stimulus
		cmd_word_t w;
		logic [15:0] s_dly;
		logic [15:0] m_dly;
		logic [15:0] lead;
		logic [15:0] tgt;
		int len;
		int roll;
		int n;
		int phase_start;
		bit paused;

		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		cmd_word = '0;
		res_stall = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the register defaults. After reset everything is
		// zero: an idle tick and a start towards position zero change nothing.
		// The first real start steps the coils at once and arms the first
		// compare match first_lead ticks on, wrapping past 65535.
		plan_add(CMD_TICK, 16'h0000, 16'h0000, 1'b1,
			fixed_result(1'b0, 2'b00, 16'd0, 16'd0, 16'd0, MODE_IDLE, 1'b0));
		plan_add(CMD_START, 16'h0000, 16'd1234, 1'b1,
			fixed_result(1'b0, 2'b00, 16'd0, 16'd0, 16'd0, MODE_IDLE, 1'b0));
		plan_add(CMD_START, 16'd3, 16'hffff, 1'b1,
			fixed_result(1'b1, 2'b01, 16'd0, 16'd999, START_DELAY_RST, MODE_ACCEL, 1'b1));
		// Three steps up: accel, decel, last, then the closing tick.
		repeat (4) plan_add(CMD_TICK, 16'hffff, 16'h0000);
		// Tick while idle again.
		plan_add(CMD_TICK, 16'h5a5a, 16'ha5a5);
		// Start towards the most negative target, then restart mid-move towards
		// the most positive one.
		plan_add(CMD_START, 16'h8000, 16'h0000);
		repeat (2) plan_add(CMD_TICK, 16'h0000, 16'hffff);
		plan_add(CMD_START, 16'h7fff, 16'h8000);
		repeat (2) plan_add(CMD_TICK, 16'h0000, 16'h0000);
		// Start towards the present position while running does nothing.
		plan_add(CMD_START, 16'd3, 16'hffff);
		// Even-length move of two steps, run to completion.
		plan_add(CMD_START, 16'd5, 16'h7fff);
		repeat (3) plan_add(CMD_TICK, 16'h0000, 16'h0000);
		// Single step downwards.
		plan_add(CMD_START, 16'd4, 16'h0001);
		repeat (2) plan_add(CMD_TICK, 16'h0000, 16'h0000);

		foreach (plan[i]) begin
			w.command = plan[i].command;
			w.target_position = plan[i].target;
			w.timer_now = plan[i].timer;
			send_word(w, plan[i].typed, plan[i].want);
		end
		drain();

		// Random part: eight phases, each with its own register setting and one of
		// four idling patterns. Every register is written in every phase.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					s_dly = START_DELAY_RST;
					m_dly = MIN_DELAY_RST;
					lead = FIRST_LEAD_RST;
				end
				1: begin
					s_dly = 16'd1;
					m_dly = 16'd1;
					lead = 16'd0;
				end
				2: begin
					s_dly = 16'hffff;
					m_dly = 16'hffff;
					lead = 16'hffff;
				end
				3: begin
					// Longest possible accel: it never reaches top speed.
					s_dly = 16'hffff;
					m_dly = 16'd1;
					lead = 16'($urandom);
				end
				default: begin
					// Top speed close enough to the start speed that short moves
					// reach constant speed and then leave it again.
					s_dly = 16'($urandom_range(200, 65535));
					m_dly = s_dly >> $urandom_range(1, 4);
					lead = 16'($urandom);
				end
			endcase
			cfg_write(REG_START_DELAY, s_dly);
			cfg_write(REG_MIN_DELAY, m_dly);
			cfg_write(REG_FIRST_LEAD, lead);

			case (ph % 4)
				0: begin
					send_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_pct = 61;
					stall_pct = 0;
				end
				2: begin
					send_pct = 0;
					stall_pct = 61;
				end
				default: begin
					send_pct = 38;
					stall_pct = 38;
				end
			endcase

			phase_start = work_items;
			paused = 1'b0;
			while (work_items - phase_start < 50) begin
				// Once per phase the sender holds off until the block has
				// handed over everything it owes.
				if (!paused && work_items - phase_start >= 25) begin
					drain();
					paused = 1'b1;
				end
				roll = $urandom_range(99);
				if (roll < 8) begin
					// Stray tick, idle or mid-move.
					issue(CMD_TICK, 16'($urandom));
				end else if (roll < 14) begin
					// Start anywhere in the field's range, abandoned early.
					issue(CMD_START, 16'($urandom));
					repeat ($urandom_range(0, 5)) issue(CMD_TICK, 16'($urandom));
				end else if (roll < 18) begin
					issue(CMD_START, prof_pos);
				end else begin
					// A complete move. Mostly short; the target may wrap the
					// signed range, which turns it into a long move the other
					// way. Moves that run past their length are cut short by
					// the next start.
					n = $urandom_range(99);
					if (n < 65)
						len = $urandom_range(1, 12);
					else if (n < 95)
						len = $urandom_range(13, 40);
					else
						len = $urandom_range(41, 150);
					tgt = $urandom_range(1) ? prof_pos - 16'(len) : prof_pos + 16'(len);
					issue(CMD_START, tgt);
					n = 0;
					while (prof_mode != MODE_IDLE && n < len + 3) begin
						issue(CMD_TICK, 16'($urandom));
						n++;
					end
				end
			end
			drain();
		end

		// Everything has been answered; give the block time to show any stray
		// word before the verdict.
		repeat (60) @(negedge clk);
		if (errors == 0)
			$display("[stepper_linear_ramp_generator] OK");
		else
			$display("[stepper_linear_ramp_generator] ERROR");
		$finish;
	end

endmodule

[files.f]
src/slrg_pkg.sv
src/stepper_linear_ramp_generator.sv
test/tb.sv
